// ===== rtl/rpa_pkg.sv =====
package rpa_pkg;

  // memory geometry
  localparam int unsigned NUM_PAGES  = 32768;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned IDX_W      = $clog2(NUM_PAGES);
  localparam int unsigned DEPTH_W    = $clog2(NUM_PAGES + 1);
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned COUNT_W    = 16;

  localparam logic [ADDR_W-1:0]  DRAM_BASE = 32'h8000_0000;
  localparam logic [ADDR_W-1:0]  PAGE_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [ADDR_W:0]    MEM_TOP   =
      (ADDR_W + 1)'(DRAM_BASE) + ((ADDR_W + 1)'(NUM_PAGES) << PAGE_SHIFT);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [ADDR_W-1:0]  FFA_RESET = 32'h8000_0000;

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_SHARE = 3'd2,
    CMD_QUERY = 3'd3,
    CMD_INIT  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OOM     = 3'd1,
    ST_BADADDR = 3'd2,
    ST_UNDER   = 3'd3,
    ST_SAT     = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture the input beat and issue reads
    logic sweep_clr;   // restart the page walk
    logic sweep_step;  // one page of the walk
    logic sweep_push;  // walk also fills the free stack
    logic commit;      // finish the item and load the result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic in_is_init;
  } dp_sts_t;

endpackage

// ===== rtl/rpa_ctrl.sv =====
module rpa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  rpa_pkg::dp_sts_t   sts_i,
  output rpa_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // output register can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // command decode
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    state_d    = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_is_init) begin
            cmd_o.sweep_clr = 1'b1;
            state_d         = S_INIT;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_INIT: begin
        cmd_o.sweep_step = 1'b1;
        cmd_o.sweep_push = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_load_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_EXEC || state_q == S_INIT))
    else $error("accepted beat did not start work");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.commit && cmd_o.sweep_step))
    else $error("commit during page walk");
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result raised outside execute");
`endif

endmodule

// ===== rtl/rpa_datapath.sv =====
module rpa_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rpa_pkg::ADDR_W-1:0]     cfg_wdata_i,
  input  logic [2:0]                     command_i,
  input  logic [rpa_pkg::ADDR_W-1:0]     page_address_i,
  input  rpa_pkg::ctrl_cmd_t             cmd_i,
  output rpa_pkg::dp_sts_t               sts_o,
  output logic [rpa_pkg::ADDR_W-1:0]     result_address_o,
  output logic [rpa_pkg::COUNT_W-1:0]    ref_count_o,
  output logic                           page_freed_o,
  output logic [2:0]                     status_o
);

  localparam int unsigned AW = rpa_pkg::ADDR_W;
  localparam int unsigned IW = rpa_pkg::IDX_W;
  localparam int unsigned DW = rpa_pkg::DEPTH_W;
  localparam int unsigned CW = rpa_pkg::COUNT_W;

  // storage
  logic [CW-1:0] count_mem [rpa_pkg::NUM_PAGES];
  logic [IW-1:0] stack_mem [rpa_pkg::NUM_PAGES];

  logic [AW-1:0] ffa_q;
  logic [DW-1:0] depth_q, depth_d;
  logic [IW-1:0] sweep_q;
  logic [DW-1:0] start_q, start_d;
  logic [2:0]    cmd_q;
  logic [AW-1:0] addr_q;
  logic [CW-1:0] cnt_rd_q;
  logic [IW-1:0] stk_rd_q;

  logic [AW-1:0] res_addr_q, res_addr_d;
  logic [CW-1:0] res_cnt_q, res_cnt_d;
  logic          res_freed_q, res_freed_d;
  logic [2:0]    res_st_q, res_st_d;

  logic [AW-1:0] in_diff, q_diff;
  logic [IW-1:0] in_idx, q_idx, cnt_ra, stk_ra;
  logic [DW-1:0] depth_m1;
  logic          addr_ok;
  logic [AW:0]   p_rnd, p_lo, p_off;
  logic [CW-1:0] cnt_dec, cnt_inc;

  logic          cw_en, sw_en;
  logic [IW-1:0] cw_addr, sw_addr, sw_data;
  logic [CW-1:0] cw_data;

  // page index from byte address
  assign in_diff = page_address_i - rpa_pkg::DRAM_BASE;
  assign q_diff  = addr_q - rpa_pkg::DRAM_BASE;
  assign in_idx  = in_diff[rpa_pkg::PAGE_SHIFT +: IW];
  assign q_idx   = q_diff[rpa_pkg::PAGE_SHIFT +: IW];

  // read addresses: live input on the accept cycle, held item afterwards
  assign cnt_ra   = cmd_i.load ? in_idx : q_idx;
  assign depth_m1 = depth_q - DW'(1);
  assign stk_ra   = depth_m1[IW-1:0];

  // address check for free, share and query
  assign addr_ok = ((addr_q & rpa_pkg::PAGE_MASK) == '0) &&
                   (addr_q >= ffa_q) &&
                   (addr_q >= rpa_pkg::DRAM_BASE) &&
                   ({1'b0, addr_q} < rpa_pkg::MEM_TOP);

  // first page of the init walk
  always_comb begin
    p_rnd = ({1'b0, ffa_q} + (AW + 1)'(rpa_pkg::PAGE_MASK)) &
            ~(AW + 1)'(rpa_pkg::PAGE_MASK);
    p_lo  = (p_rnd < (AW + 1)'(rpa_pkg::DRAM_BASE)) ?
            (AW + 1)'(rpa_pkg::DRAM_BASE) : p_rnd;
    p_off = p_lo - (AW + 1)'(rpa_pkg::DRAM_BASE);
    if (p_lo >= rpa_pkg::MEM_TOP) begin
      start_d = DW'(rpa_pkg::NUM_PAGES);
    end else begin
      start_d = DW'(p_off >> rpa_pkg::PAGE_SHIFT);
    end
  end

  assign cnt_dec = cnt_rd_q - CW'(1);
  assign cnt_inc = cnt_rd_q + CW'(1);

  // item execution and page walk
  always_comb begin
    res_addr_d  = addr_q;
    res_cnt_d   = '0;
    res_freed_d = 1'b0;
    res_st_d    = rpa_pkg::ST_OK;
    cw_en       = 1'b0;
    cw_addr     = q_idx;
    cw_data     = '0;
    sw_en       = 1'b0;
    sw_addr     = depth_q[IW-1:0];
    sw_data     = q_idx;
    depth_d     = depth_q;
    if (cmd_i.sweep_clr) begin
      depth_d = '0;
    end else if (cmd_i.sweep_step) begin
      cw_en   = 1'b1;
      cw_addr = sweep_q;
      if (cmd_i.sweep_push && ({1'b0, sweep_q} >= start_q)) begin
        sw_en   = 1'b1;
        sw_data = sweep_q;
        depth_d = depth_q + DW'(1);
      end
    end else if (cmd_i.commit) begin
      case (cmd_q)
        rpa_pkg::CMD_ALLOC: begin
          if (depth_q == '0) begin
            res_addr_d = '0;
            res_st_d   = rpa_pkg::ST_OOM;
          end else begin
            depth_d    = depth_m1;
            cw_en      = 1'b1;
            cw_addr    = stk_rd_q;
            cw_data    = CW'(1);
            res_addr_d = rpa_pkg::DRAM_BASE + (AW'(stk_rd_q) << rpa_pkg::PAGE_SHIFT);
            res_cnt_d  = CW'(1);
          end
        end
        rpa_pkg::CMD_FREE: begin
          if (!addr_ok) begin
            res_st_d = rpa_pkg::ST_BADADDR;
          end else if (cnt_rd_q == '0) begin
            res_st_d = rpa_pkg::ST_UNDER;
          end else begin
            cw_en     = 1'b1;
            cw_data   = cnt_dec;
            res_cnt_d = cnt_dec;
            if ((cnt_dec == '0) && (depth_q < DW'(rpa_pkg::NUM_PAGES))) begin
              sw_en       = 1'b1;
              depth_d     = depth_q + DW'(1);
              res_freed_d = 1'b1;
            end
          end
        end
        rpa_pkg::CMD_SHARE: begin
          if (!addr_ok) begin
            res_st_d = rpa_pkg::ST_BADADDR;
          end else if (cnt_rd_q == rpa_pkg::COUNT_MAX) begin
            res_st_d  = rpa_pkg::ST_SAT;
            res_cnt_d = cnt_rd_q;
          end else begin
            cw_en     = 1'b1;
            cw_data   = cnt_inc;
            res_cnt_d = cnt_inc;
          end
        end
        rpa_pkg::CMD_QUERY: begin
          if (!addr_ok) begin
            res_st_d = rpa_pkg::ST_BADADDR;
          end else begin
            res_cnt_d = cnt_rd_q;
          end
        end
        default: begin
          res_st_d = rpa_pkg::ST_OK;
        end
      endcase
    end
  end

  // count memory
  always_ff @(posedge clk_i) begin
    if (cw_en) begin
      count_mem[cw_addr] <= cw_data;
    end
    cnt_rd_q <= count_mem[cnt_ra];
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if (sw_en) begin
      stack_mem[sw_addr] <= sw_data;
    end
    stk_rd_q <= stack_mem[stk_ra];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ffa_q   <= rpa_pkg::FFA_RESET;
      depth_q <= '0;
      sweep_q <= '0;
    end else begin
      if (cfg_we_i) begin
        ffa_q <= cfg_wdata_i;
      end
      depth_q <= depth_d;
      if (cmd_i.sweep_clr) begin
        sweep_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sweep_q <= sweep_q + IW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= command_i;
      addr_q <= page_address_i;
    end
    if (cmd_i.sweep_clr) begin
      start_q <= start_d;
    end
    if (cmd_i.commit) begin
      res_addr_q  <= res_addr_d;
      res_cnt_q   <= res_cnt_d;
      res_freed_q <= res_freed_d;
      res_st_q    <= res_st_d;
    end
  end

  assign sts_o.sweep_last = (sweep_q == IW'(rpa_pkg::NUM_PAGES - 1));
  assign sts_o.in_is_init = (command_i == rpa_pkg::CMD_INIT);

  assign result_address_o = res_addr_q;
  assign ref_count_o      = res_cnt_q;
  assign page_freed_o     = res_freed_q;
  assign status_o         = res_st_q;

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(rpa_pkg::NUM_PAGES))
    else $error("free stack depth beyond page count");
`endif

endmodule

// ===== rtl/refcounted_page_allocator.sv =====
// alloc, free, share, query and unknown commands: execute after the input beat, result registered
// init: walks every page once, then executes and registers its result
// a new beat is taken only in idle, after the last item commits; counts are read-modify-write
// reset is asynchronous, active low; afterwards a clearing pass over every page
// zeroes the count memory while input stays stalled (config writes still taken)
module refcounted_page_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rpa_pkg::ADDR_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  command_i,
  input  logic [rpa_pkg::ADDR_W-1:0]  page_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rpa_pkg::ADDR_W-1:0]  result_address_o,
  output logic [rpa_pkg::COUNT_W-1:0] ref_count_o,
  output logic                        page_freed_o,
  output logic [2:0]                  status_o
);

  rpa_pkg::ctrl_cmd_t cmd;
  rpa_pkg::dp_sts_t   sts;

  // sequencing
  rpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // counts, free stack and result registers
  rpa_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .command_i        (command_i),
    .page_address_i   (page_address_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .result_address_o (result_address_o),
    .ref_count_o      (ref_count_o),
    .page_freed_o     (page_freed_o),
    .status_o         (status_o)
  );

endmodule
